// ===== hw/rtl/turbidity_average_calibrate_classify_top_defines.svh =====
// Assertion macros shared by the checker of the turbidity averaging block.
// No dependencies; take it in by `include with the bare file name.
`ifndef TURBIDITY_AVERAGE_CALIBRATE_CLASSIFY_TOP_DEFINES_SVH
`define TURBIDITY_AVERAGE_CALIBRATE_CLASSIFY_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TACC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tacc check failed: same-cycle property");

// Consequent must hold in the cycle after the antecedent.
`define TACC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tacc check failed: next-cycle property");

`endif

// ===== hw/rtl/tacc_pkg.sv =====
// Types and constants of the turbidity averaging / calibration block.
// Used by tacc_regs, tacc_ctrl, tacc_dp and the top level; no dependencies.
package tacc_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int SUM_W       = 16;
    localparam int CNT_W       = 6;
    localparam int MEAN_W      = 18;
    localparam int VALUE_W     = 32;
    localparam int QUAL_W      = 2;
    localparam int COEF_W      = 48;
    localparam int THR_W       = 10;
    localparam int ACC_W       = 96;
    localparam int CHUNK_W     = 32;
    localparam int PROD_W      = 52;
    localparam int DIVIDEND_W  = 24;
    localparam int RECIP_W     = 32;
    localparam int RECIP_SHIFT = 31;
    localparam int DIVPROD_W   = DIVIDEND_W + RECIP_W;
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 6;
    localparam int REG_IDX_W   = 3;

    // Register indexes (byte address is 8 * index)
    localparam logic [REG_IDX_W-1:0] REG_POLY_ENABLE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_CUBIC      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_SQUARE     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_LINEAR     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_OFFSET     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CLEAR_THRESHOLD = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MURKY_THRESHOLD = 3'd6;

    // Quality codes
    localparam logic [QUAL_W-1:0] QUAL_CLEAR  = 2'd0;
    localparam logic [QUAL_W-1:0] QUAL_MURKY  = 2'd1;
    localparam logic [QUAL_W-1:0] QUAL_TURBID = 2'd2;

    // Horner sequencing: three 32-bit chunks of the accumulator, three terms
    localparam logic [1:0] CHUNK_LAST = 2'd2;
    localparam logic [1:0] TERM_LAST  = 2'd2;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

    typedef struct packed {
        logic              poly_enable;
        logic [COEF_W-1:0] coef_cubic;
        logic [COEF_W-1:0] coef_square;
        logic [COEF_W-1:0] coef_linear;
        logic [COEF_W-1:0] coef_offset;
        logic [THR_W-1:0]  clear_threshold;
        logic [THR_W-1:0]  murky_threshold;
    } tacc_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_MUL,
        ST_DIV_Q,
        ST_POLY_LOAD,
        ST_POLY_MUL,
        ST_POLY_ADD,
        ST_POLY_STEP,
        ST_POLY_ROUND,
        ST_OUT
    } tacc_state_t;

    typedef struct packed {
        logic take;
        logic div_mul;
        logic div_q;
        logic poly_load;
        logic mul;
        logic add;
        logic step;
        logic round;
        logic out_load;
    } tacc_cmd_t;

    typedef struct packed {
        logic group_last;
        logic chunk_last;
        logic term_last;
        logic out_free;
    } tacc_status_t;

endpackage

// ===== hw/rtl/tacc_regs.sv =====
// Configuration register file with an APB-style slave port.
// Depends on tacc_pkg for the register map and the config struct.
module tacc_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tacc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tacc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tacc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output tacc_pkg::tacc_cfg_t            cfg
);
    import tacc_pkg::*;

    tacc_cfg_t             cfg_reg;
    tacc_cfg_t             cfg_next;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_POLY_ENABLE:     cfg_next.poly_enable     = pwdata[0];
                REG_COEF_CUBIC:      cfg_next.coef_cubic      = pwdata[COEF_W-1:0];
                REG_COEF_SQUARE:     cfg_next.coef_square     = pwdata[COEF_W-1:0];
                REG_COEF_LINEAR:     cfg_next.coef_linear     = pwdata[COEF_W-1:0];
                REG_COEF_OFFSET:     cfg_next.coef_offset     = pwdata[COEF_W-1:0];
                REG_CLEAR_THRESHOLD: cfg_next.clear_threshold = pwdata[THR_W-1:0];
                REG_MURKY_THRESHOLD: cfg_next.murky_threshold = pwdata[THR_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_POLY_ENABLE:     prdata = APB_DATA_W'(cfg_reg.poly_enable);
            REG_COEF_CUBIC:      prdata = APB_DATA_W'(cfg_reg.coef_cubic);
            REG_COEF_SQUARE:     prdata = APB_DATA_W'(cfg_reg.coef_square);
            REG_COEF_LINEAR:     prdata = APB_DATA_W'(cfg_reg.coef_linear);
            REG_COEF_OFFSET:     prdata = APB_DATA_W'(cfg_reg.coef_offset);
            REG_CLEAR_THRESHOLD: prdata = APB_DATA_W'(cfg_reg.clear_threshold);
            REG_MURKY_THRESHOLD: prdata = APB_DATA_W'(cfg_reg.murky_threshold);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/tacc_ctrl.sv =====
// Controller state machine: sequences accumulation, division, Horner steps
// and the output load. Depends on tacc_pkg for states, commands and status.
module tacc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   poly_enable,
    input  tacc_pkg::tacc_status_t status,
    output logic                   in_stall,
    output tacc_pkg::tacc_cmd_t    cmd
);
    import tacc_pkg::*;

    tacc_state_t state_reg;
    tacc_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.group_last)
                begin
                    state_next = ST_DIV_MUL;
                end
            end
            ST_DIV_MUL:    state_next = ST_DIV_Q;
            ST_DIV_Q:      state_next = poly_enable ? ST_POLY_LOAD : ST_OUT;
            ST_POLY_LOAD:  state_next = ST_POLY_MUL;
            ST_POLY_MUL:   state_next = ST_POLY_ADD;
            ST_POLY_ADD:   state_next = status.chunk_last ? ST_POLY_STEP : ST_POLY_MUL;
            ST_POLY_STEP:  state_next = status.term_last ? ST_POLY_ROUND : ST_POLY_MUL;
            ST_POLY_ROUND: state_next = ST_OUT;
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
            end
            ST_DIV_MUL:    cmd.div_mul   = 1'b1;
            ST_DIV_Q:      cmd.div_q     = 1'b1;
            ST_POLY_LOAD:  cmd.poly_load = 1'b1;
            ST_POLY_MUL:   cmd.mul       = 1'b1;
            ST_POLY_ADD:   cmd.add       = 1'b1;
            ST_POLY_STEP:  cmd.step      = 1'b1;
            ST_POLY_ROUND: cmd.round     = 1'b1;
            ST_OUT:        cmd.out_load  = status.out_free;
            default:       cmd           = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/tacc_dp.sv =====
// Datapath: sample accumulator, reciprocal divider, chunked Horner
// multiplier, classifier and output register. Depends on tacc_pkg.
module tacc_dp #(
    parameter int SAMPLES_PER_RESULT = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tacc_pkg::tacc_cmd_t            cmd,
    input  tacc_pkg::tacc_cfg_t            cfg,
    input  logic [tacc_pkg::SAMPLE_W-1:0]  adc_sample,
    input  logic                           out_stall,
    output tacc_pkg::tacc_status_t         status,
    output logic                           out_valid,
    output logic [tacc_pkg::MEAN_W-1:0]    mean_q,
    output logic [tacc_pkg::VALUE_W-1:0]   value_q,
    output logic [tacc_pkg::QUAL_W-1:0]    quality,
    output logic                           saturated
);
    import tacc_pkg::*;

    localparam logic [CNT_W-1:0]      LAST_CNT  = CNT_W'(SAMPLES_PER_RESULT - 1);
    localparam logic [6:0]            N_VAL     = 7'(SAMPLES_PER_RESULT);
    localparam logic [DIVIDEND_W-1:0] HALF_N    = DIVIDEND_W'(SAMPLES_PER_RESULT / 2);
    // ceil(2^31 / N): exact quotient for every dividend below 2^24
    localparam logic [RECIP_W-1:0]    RECIP     =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SAMPLES_PER_RESULT) - 64'd1)
                 / 64'(SAMPLES_PER_RESULT));
    localparam logic [ACC_W-1:0]      STEP_HALF = ACC_W'(128);
    localparam logic [ACC_W-1:0]      OUT_HALF  = ACC_W'(1) << 23;

    // accumulation
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SUM_W-1:0]     hold_sum_reg, hold_sum_next;
    logic [SUM_W-1:0]     sum_add;
    // division and classification
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVPROD_W-1:0]  divprod_reg, divprod_next;
    logic [MEAN_W-1:0]     mean_reg, mean_next;
    logic [QUAL_W-1:0]     qual_reg, qual_next;
    logic [16:0]           clear_lim;
    logic [16:0]           murky_lim;
    // Horner evaluation
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  pacc_reg, pacc_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [1:0]               chunk_reg, chunk_next;
    logic [1:0]               term_reg, term_next;
    logic signed [CHUNK_W:0]  chunk_op;
    logic signed [MEAN_W:0]   x_op;
    logic [ACC_W-1:0]         prod_ext;
    logic [ACC_W-1:0]         prod_shift;
    logic [COEF_W-1:0]        coef_sel;
    logic signed [ACC_W-1:0]  step_round;
    logic signed [ACC_W-1:0]  out_round;
    logic                     clip;
    logic [VALUE_W-1:0]       val_reg, val_next;
    logic                     sat_reg, sat_next;
    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [MEAN_W-1:0]    mean_out_reg, mean_out_next;
    logic [VALUE_W-1:0]   value_out_reg, value_out_next;
    logic [QUAL_W-1:0]    qual_out_reg, qual_out_next;
    logic                 sat_out_reg, sat_out_next;

    assign sum_add   = sum_reg + SUM_W'(adc_sample);
    assign dividend  = {hold_sum_reg, 8'b0} + HALF_N;
    assign clear_lim = {10'b0, N_VAL} * {7'b0, cfg.clear_threshold};
    assign murky_lim = {10'b0, N_VAL} * {7'b0, cfg.murky_threshold};

    always_comb
    begin
        case (chunk_reg)
            2'd0:    chunk_op = $signed({1'b0, acc_reg[CHUNK_W-1:0]});
            2'd1:    chunk_op = $signed({1'b0, acc_reg[2*CHUNK_W-1:CHUNK_W]});
            default: chunk_op = $signed({acc_reg[ACC_W-1], acc_reg[ACC_W-1:2*CHUNK_W]});
        endcase
    end

    assign x_op     = $signed({1'b0, mean_reg});
    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        case (chunk_reg)
            2'd0:    prod_shift = prod_ext;
            2'd1:    prod_shift = prod_ext << CHUNK_W;
            default: prod_shift = prod_ext << (2 * CHUNK_W);
        endcase
    end

    always_comb
    begin
        case (term_reg)
            2'd0:    coef_sel = cfg.coef_square;
            2'd1:    coef_sel = cfg.coef_linear;
            default: coef_sel = cfg.coef_offset;
        endcase
    end

    assign step_round = $signed(pacc_reg + STEP_HALF) >>> 8;
    assign out_round  = $signed(acc_reg + OUT_HALF) >>> 24;
    assign clip       = (out_round[ACC_W-1:VALUE_W-1] != '0)
                     && (out_round[ACC_W-1:VALUE_W-1] != '1);

    always_comb
    begin
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        hold_sum_next  = hold_sum_reg;
        divprod_next   = divprod_reg;
        mean_next      = mean_reg;
        qual_next      = qual_reg;
        acc_next       = acc_reg;
        pacc_next      = pacc_reg;
        prod_next      = prod_reg;
        chunk_next     = chunk_reg;
        term_next      = term_reg;
        val_next       = val_reg;
        sat_next       = sat_reg;
        mean_out_next  = mean_out_reg;
        value_out_next = value_out_reg;
        qual_out_next  = qual_out_reg;
        sat_out_next   = sat_out_reg;

        if (cmd.take)
        begin
            if (cnt_reg == LAST_CNT)
            begin
                hold_sum_next = sum_add;
                sum_next      = '0;
                cnt_next      = '0;
            end
            else
            begin
                sum_next = sum_add;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end

        if (cmd.div_mul)
        begin
            divprod_next = {{RECIP_W{1'b0}}, dividend} * {{DIVIDEND_W{1'b0}}, RECIP};
        end

        if (cmd.div_q)
        begin
            mean_next = divprod_reg[RECIP_SHIFT +: MEAN_W];
            if ({1'b0, hold_sum_reg} > clear_lim)
            begin
                qual_next = QUAL_CLEAR;
            end
            else if ({1'b0, hold_sum_reg} > murky_lim)
            begin
                qual_next = QUAL_MURKY;
            end
            else
            begin
                qual_next = QUAL_TURBID;
            end
        end

        if (cmd.poly_load)
        begin
            acc_next   = {{(ACC_W-COEF_W){cfg.coef_cubic[COEF_W-1]}}, cfg.coef_cubic};
            pacc_next  = '0;
            chunk_next = '0;
            term_next  = '0;
        end

        if (cmd.mul)
        begin
            prod_next = PROD_W'(chunk_op * x_op);
        end

        if (cmd.add)
        begin
            pacc_next  = pacc_reg + prod_shift;
            chunk_next = chunk_reg + 2'd1;
        end

        if (cmd.step)
        begin
            acc_next   = step_round + {{(ACC_W-COEF_W){coef_sel[COEF_W-1]}}, coef_sel};
            pacc_next  = '0;
            chunk_next = '0;
            term_next  = term_reg + 2'd1;
        end

        if (cmd.round)
        begin
            sat_next = clip;
            if (!clip)
            begin
                val_next = out_round[VALUE_W-1:0];
            end
            else if (out_round[ACC_W-1])
            begin
                val_next = VALUE_MIN;
            end
            else
            begin
                val_next = VALUE_MAX;
            end
        end

        if (cmd.out_load)
        begin
            mean_out_next  = mean_reg;
            qual_out_next  = qual_reg;
            value_out_next = cfg.poly_enable ? val_reg : VALUE_W'(mean_reg);
            sat_out_next   = cfg.poly_enable && sat_reg;
        end
    end

    // hold while the receiver stalls, drop once the transfer completes
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    assign status.group_last = (cnt_reg == LAST_CNT);
    assign status.chunk_last = (chunk_reg == CHUNK_LAST);
    assign status.term_last  = (term_reg == TERM_LAST);
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign mean_q    = mean_out_reg;
    assign value_q   = value_out_reg;
    assign quality   = qual_out_reg;
    assign saturated = sat_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            chunk_reg     <= '0;
            term_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            chunk_reg     <= chunk_next;
            term_reg      <= term_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_sum_reg  <= hold_sum_next;
        divprod_reg   <= divprod_next;
        mean_reg      <= mean_next;
        qual_reg      <= qual_next;
        acc_reg       <= acc_next;
        pacc_reg      <= pacc_next;
        prod_reg      <= prod_next;
        val_reg       <= val_next;
        sat_reg       <= sat_next;
        mean_out_reg  <= mean_out_next;
        value_out_reg <= value_out_next;
        qual_out_reg  <= qual_out_next;
        sat_out_reg   <= sat_out_next;
    end

endmodule

// ===== hw/rtl/turbidity_average_calibrate_classify_top.sv =====
// Top level of the turbidity averaging, calibration and classification block.
// Instantiates tacc_regs, tacc_ctrl and tacc_dp; depends on tacc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / adc_sample) takes one 10-bit reading
//   per transfer. Samples that do not close a group are taken one per cycle
//   while idle. The sample that closes a group of SAMPLES_PER_RESULT starts
//   the result computation; in_stall stays high until the result is in the
//   output register: reciprocal multiply, quotient, then with poly_enable set
//   a load, three Horner steps (the 96-bit accumulator multiplied in three
//   32-bit chunks, a multiply and an add each) and a final rounding.
//   Output channel (out_valid / out_stall) carries mean_q, value_q, quality
//   and saturated. The output register holds its result while out_stall is
//   high; the next group's samples are still taken meanwhile, and a finished
//   group waits in its last state until the output register is free.
//   Configuration goes through the APB port (64-bit data, register i at byte
//   address 8*i); it must be written only while the block is idle, which the
//   block does not enforce. Reset (rst_n low) clears the sum, the sample
//   count, the configuration and control registers and the output valid flag.
module turbidity_average_calibrate_classify_top #(
    parameter int SAMPLES_PER_RESULT = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tacc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tacc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tacc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tacc_pkg::SAMPLE_W-1:0]   adc_sample,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tacc_pkg::MEAN_W-1:0]     mean_q,
    output logic [tacc_pkg::VALUE_W-1:0]    value_q,
    output logic [tacc_pkg::QUAL_W-1:0]     quality,
    output logic                            saturated
);
    import tacc_pkg::*;

    tacc_cfg_t    cfg;
    tacc_cmd_t    cmd;
    tacc_status_t status;

    tacc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tacc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .poly_enable (cfg.poly_enable),
        .status      (status),
        .in_stall    (in_stall),
        .cmd         (cmd)
    );

    tacc_dp #(
        .SAMPLES_PER_RESULT (SAMPLES_PER_RESULT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg),
        .adc_sample (adc_sample),
        .out_stall  (out_stall),
        .status     (status),
        .out_valid  (out_valid),
        .mean_q     (mean_q),
        .value_q    (value_q),
        .quality    (quality),
        .saturated  (saturated)
    );

endmodule

// ===== hw/rtl/tacc_checker.sv =====
// Port-level checker for the turbidity block, bound to the top level.
// Depends on turbidity_average_calibrate_classify_top_defines.svh.
`include "turbidity_average_calibrate_classify_top_defines.svh"

module tacc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [17:0] mean_q,
    input logic [31:0] value_q,
    input logic [1:0]  quality,
    input logic        saturated
);

    // a stalled result stays on the port unchanged
    `TACC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(mean_q) && $stable(value_q) && $stable(quality) && $stable(saturated))

    // a clipped value sits exactly at one end of the Q23.8 range
    `TACC_ASSERT_NOW(a_sat_value, clk, rst_n, out_valid && saturated, value_q == 32'h7fff_ffff || value_q == 32'h8000_0000)

    // the mean of 10-bit samples never exceeds full scale in Q10.8
    `TACC_ASSERT_NOW(a_mean_range, clk, rst_n, out_valid, mean_q <= 18'd261888)

endmodule

bind turbidity_average_calibrate_classify_top tacc_checker u_tacc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mean_q    (mean_q),
    .value_q   (value_q),
    .quality   (quality),
    .saturated (saturated)
);
